@@ hw/rtl/mavg_pkg.sv @@
`default_nettype none
package mavg_pkg;

   // default depth of the sample ring
   localparam int unsigned PERIOD_MAX_DEF = 256;

   // register fields
   localparam int unsigned PERIOD_W = 9;
   localparam int unsigned METHOD_W = 2;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd13;
   localparam logic [METHOD_W-1:0] METHOD_RESET = 2'd0;

   // averaging methods
   localparam logic [METHOD_W-1:0] METHOD_SIMPLE   = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_EXP      = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_SMOOTHED = 2'd2;
   localparam logic [METHOD_W-1:0] METHOD_WEIGHTED = 2'd3;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD = 3'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_METHOD = 3'h4;

   // sample width
   localparam int unsigned DATA_W = 32;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_DIVS,
      ST_DIVW,
      ST_OUT
   } seq_state_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic in_ready;
      logic walk_en;
      logic div_start;
      logic out_try;
      logic load_en;
   } seq_ctrl_type;

endpackage
`default_nettype wire

@@ hw/rtl/mavg_ram.sv @@
`default_nettype none
module mavg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ hw/rtl/mavg_div.sv @@
`default_nettype none
module mavg_div #(
   parameter int unsigned NW = 51,
   parameter int unsigned DW = 18
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [NW-1:0] dividend,
   input  wire logic [DW-1:0]        divisor,
   output logic                      done,
   output logic signed [NW-1:0]      quotient
);
   localparam int unsigned CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic          neg_ff, neg_in;

   logic [DW:0]   trial;
   logic          fits;

   // one restoring step per cycle on magnitudes
   always_comb begin
      trial   = {rem_ff, q_ff[NW-1]};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         neg_in  = dividend[NW-1];
         q_in    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DW-1:0];
         end
         q_in   = {q_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // truncation toward zero: sign of the dividend on the magnitude
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule
`default_nettype wire

@@ hw/rtl/moving_average_four_mode_unit.sv @@
`default_nettype none
// flow: a transferred sample is stored, then cnt terms are added (stored samples, up to PERIOD_MAX,
// one ring read a cycle, or the last average alone in exponential and steady smoothed modes), then
// a bit-serial divide of 2*clog2(PERIOD_MAX+1)+33 steps runs and the result is registered
// throughput: one sample at a time, the next accepted once the previous result is registered
// reset: synchronous, period 13, method simple, bar count, ring pointer and last average zero
module moving_average_four_mode_unit
   import mavg_pkg::PERIOD_MAX_DEF, mavg_pkg::CSR_ADDR_W;
#(
   parameter int unsigned PERIOD_MAX = PERIOD_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // [31:0] sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [31:0]           rsp_tdata,   // [31:0] average
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);
   import mavg_pkg::*;

   localparam int unsigned AW    = $clog2(PERIOD_MAX);
   localparam int unsigned PW    = $clog2(PERIOD_MAX + 1);
   localparam int unsigned XW    = (PW > PERIOD_W) ? PW : PERIOD_W;
   localparam int unsigned DVW   = 2 * PW;
   localparam int unsigned ACC_W = 33 + 2 * PW;
   localparam int unsigned MW    = DATA_W + PW + 1;

   seq_state_type state_ff, state_in;
   seq_ctrl_type  ctrl;

   logic [PERIOD_W-1:0]      period_ff;
   logic [METHOD_W-1:0]      method_ff;
   logic [AW-1:0]            slot_ff, slot_in;
   logic [PW-1:0]            bars_ff;
   logic signed [DATA_W-1:0] last_ff;
   logic signed [DATA_W-1:0] x_ff;

   logic [PW-1:0]            cnt_ff, cnt_in;
   logic [PW-1:0]            iss_ff;
   logic [AW-1:0]            raddr_ff;
   logic [PW-1:0]            wt_ff, wt_in;
   logic                     wdec_ff, wdec_in;
   logic                     inj_ff, inj_in;
   logic [DVW-1:0]           divisor_ff, divisor_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     v1_ff, v2_ff;
   logic [PW-1:0]            w1_ff;
   logic signed [MW-1:0]     prod_ff;
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_data_ff;

   logic                     accept, issue, walk_done, div_done, out_fire, csr_wr;
   logic [XW-1:0]            per_x;
   logic [PW-1:0]            p_eff, m_cur;
   logic [2*PW+1:0]          tri_full;
   logic [DATA_W-1:0]        ram_rdata;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [ACC_W-1:0]  x_ext, quot;
   logic [DATA_W-1:0]        avg_sat;
   logic                     q_fits;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   always_comb begin
      if (csr_paddr[2] == CSR_METHOD[2]) begin
         csr_prdata = {{(32 - METHOD_W){1'b0}}, method_ff};
      end else begin
         csr_prdata = {{(32 - PERIOD_W){1'b0}}, period_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         method_ff <= METHOD_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_METHOD[2]) begin
            method_ff <= csr_pwdata[METHOD_W-1:0];
         end else begin
            period_ff <= csr_pwdata[PERIOD_W-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_WALK;
         ST_WALK: if (walk_done) state_in = ST_DIVS;
         ST_DIVS: state_in = ST_DIVW;
         ST_DIVW: if (div_done) state_in = ST_OUT;
         ST_OUT:  if (out_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: ctrl.in_ready  = 1'b1;
         ST_LOAD: ctrl.load_en   = 1'b1;
         ST_WALK: ctrl.walk_en   = 1'b1;
         ST_DIVS: ctrl.div_start = 1'b1;
         ST_OUT:  ctrl.out_try   = 1'b1;
         default: ctrl = '0;
      endcase
   end

   assign req_tready = ctrl.in_ready;
   assign accept     = req_tvalid & ctrl.in_ready;
   assign issue      = ctrl.walk_en & (iss_ff != cnt_ff);
   assign walk_done  = (iss_ff == cnt_ff) & ~v1_ff & ~v2_ff;
   assign out_fire   = ctrl.out_try & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sample ring
   assign slot_in = (slot_ff == AW'(PERIOD_MAX - 1)) ? '0 : slot_ff + 1'b1;

   mavg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (PERIOD_MAX)
   ) u_ring (
      .clock (clock),
      .we    (accept),
      .waddr (slot_ff),
      .wdata (req_tdata),
      .raddr (raddr_ff),
      .rdata (ram_rdata)
   );

   // effective period and window length
   always_comb begin
      per_x = XW'(period_ff);
      if (per_x < XW'(2)) begin
         p_eff = PW'(2);
      end else if (per_x > XW'(PERIOD_MAX)) begin
         p_eff = PW'(PERIOD_MAX);
      end else begin
         p_eff = per_x[PW-1:0];
      end
      m_cur    = (bars_ff < p_eff) ? bars_ff : p_eff;
      tri_full = (2*PW+2)'(m_cur) * (2*PW+2)'({1'b0, m_cur} + 1'b1);
      x_ext    = ACC_W'(x_ff);
   end

   // per-method set-up of the walk and the divisor
   always_comb begin
      cnt_in     = '0;
      wt_in      = PW'(1);
      wdec_in    = 1'b0;
      inj_in     = 1'b0;
      acc_in     = x_ext;
      divisor_in = DVW'(1);
      case (method_ff)
         METHOD_SIMPLE: begin
            if (m_cur != '0) begin
               cnt_in     = m_cur;
               acc_in     = '0;
               divisor_in = DVW'(m_cur);
            end
         end
         METHOD_EXP: begin
            if (m_cur != '0) begin
               cnt_in     = PW'(1);
               inj_in     = 1'b1;
               wt_in      = m_cur - 1'b1;
               acc_in     = x_ext <<< 1;
               divisor_in = DVW'(m_cur) + 1'b1;
            end
         end
         METHOD_SMOOTHED: begin
            if (bars_ff < p_eff) begin
               cnt_in     = bars_ff + 1'b1;
               acc_in     = '0;
               divisor_in = DVW'(bars_ff) + 1'b1;
            end else begin
               cnt_in     = PW'(1);
               inj_in     = 1'b1;
               wt_in      = p_eff - 1'b1;
               divisor_in = DVW'(p_eff);
            end
         end
         METHOD_WEIGHTED: begin
            if (m_cur != '0) begin
               cnt_in     = m_cur;
               wt_in      = m_cur;
               wdec_in    = 1'b1;
               acc_in     = '0;
               divisor_in = tri_full[DVW:1];
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // shared multiply and accumulate
   assign mul_a = inj_ff ? last_ff : $signed(ram_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         bars_ff      <= '0;
         last_ff      <= '0;
         iss_ff       <= '0;
         cnt_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (accept) begin
            slot_ff <= slot_in;
         end
         if (ctrl.load_en) begin
            cnt_ff <= cnt_in;
            iss_ff <= '0;
         end else if (issue) begin
            iss_ff <= iss_ff + 1'b1;
         end
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
            last_ff      <= $signed(avg_sat);
            if (bars_ff < PW'(PERIOD_MAX)) begin
               bars_ff <= bars_ff + 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= $signed(req_tdata);
         raddr_ff <= slot_ff;
      end else if (issue) begin
         raddr_ff <= (raddr_ff == '0) ? AW'(PERIOD_MAX - 1) : raddr_ff - 1'b1;
      end
      if (ctrl.load_en) begin
         wt_ff      <= wt_in;
         wdec_ff    <= wdec_in;
         inj_ff     <= inj_in;
         divisor_ff <= divisor_in;
      end else if (issue & wdec_ff) begin
         wt_ff <= wt_ff - 1'b1;
      end
      w1_ff   <= wt_ff;
      prod_ff <= MW'(mul_a) * $signed(MW'({1'b0, w1_ff}));
      if (ctrl.load_en) begin
         acc_ff <= acc_in;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (out_fire) begin
         rsp_data_ff <= avg_sat;
      end
   end

   // shared divider
   mavg_div #(
      .NW (ACC_W),
      .DW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (acc_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // saturate to 32 bits
   always_comb begin
      q_fits = (&quot[ACC_W-1:DATA_W-1]) | ~(|quot[ACC_W-1:DATA_W-1]);
      if (q_fits) begin
         avg_sat = quot[DATA_W-1:0];
      end else if (quot[ACC_W-1]) begin
         avg_sat = {1'b1, {(DATA_W - 1){1'b0}}};
      end else begin
         avg_sat = {1'b0, {(DATA_W - 1){1'b1}}};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire
